[rtl/ssms_pkg.sv]
// ssms_pkg: widths, step counts, codes and the state type of the sample stack
// statistics block; shared by the top level and its port checker
// no dependencies
`default_nettype none

package ssms_pkg;

   // field widths
   localparam int SAMPLE_W  = 24;   // one Q11.12 sample
   localparam int COUNT_W   = 11;   // held count, up to 1024
   localparam int SUM_W     = 34;   // running sum, signed
   localparam int SQSUM_W   = 57;   // running sum of squares
   localparam int SQ_W      = 48;   // square of one sample magnitude
   localparam int PROD_W    = 68;   // n*S2 and S1^2
   localparam int DEN_W     = 30;   // n*n*(n-1)
   localparam int QUO_W     = 46;   // quotient bits kept below saturation
   localparam int ERR_W     = 23;   // standard error
   localparam int STATUS_W  = 2;
   localparam int STEP_W    = 7;

   // stream layout
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 3;
   localparam int RSP_PAD_W   = RSP_TDATA_W - COUNT_W - SAMPLE_W - ERR_W;

   // serial step counts
   localparam int SQ_STEPS   = 24;                // one bit of the sample magnitude a cycle
   localparam int MUL_STEPS  = 34;                // one bit of |S1| a cycle
   localparam int DIV_STEPS  = 68;                // one dividend bit a cycle
   localparam int ROOT_STEPS = 23;                // two radicand bits a cycle
   localparam int OVER_STEPS = PROD_W - QUO_W;    // leading steps whose quotient bit saturates

   localparam logic [ERR_W-1:0] ERR_MAX = '1;

   typedef enum logic [0:0] {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_APPLY,
      ST_PREP,
      ST_MULT,
      ST_DIFF,
      ST_DIVIDE,
      ST_ROOT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[rtl/sample_stack_mean_stderr.sv]
// sample_stack_mean_stderr: stack of Q11.12 samples with running sums, answering every
// transfer with count, mean and standard error of the mean through bit-serial units
// depends on ssms_pkg
`default_nettype none

// Each request either pushes a signed Q11.12 sample or pops the newest one, and each is
// answered by exactly one response carrying the count held afterwards, the mean
// truncated toward zero and floor(sqrt((n*S2-S1^2)/(n*n*(n-1)))) saturated to 23 bits,
// flagged valid from two samples on. A request passes from its transfer through the load,
// the squaring of the sample, the update, the set-up, the shift-add products and the mean
// divider that run side by side, the difference, the restoring divider, the longest step,
// the square root and the handover before the earliest next transfer.
// A finished response waits in its own register, so the next request is taken while it
// is still pending; a response that finds that register still occupied holds the block
// in its handover step until the pending one has gone out.
// The sample store needs no clearing pass after reset.
module sample_stack_mean_stderr #(
   parameter int STORE_DEPTH = 1024
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [ssms_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [23:0] sample
   input  wire  [ssms_pkg::REQ_TUSER_W-1:0]    req_tuser,   // [0] req_type
   // response channel
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [ssms_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [10:0] sample_count,
                                                            // [34:11] mean_value,
                                                            // [57:35] std_error, rest zero
   output logic [ssms_pkg::RSP_TUSER_W-1:0]    rsp_tuser    // [0] error_valid, [2:1] status
);

   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int SAMPLE_W = ssms_pkg::SAMPLE_W;
   localparam int COUNT_W  = ssms_pkg::COUNT_W;
   localparam int SUM_W    = ssms_pkg::SUM_W;
   localparam int SQSUM_W  = ssms_pkg::SQSUM_W;
   localparam int SQ_W     = ssms_pkg::SQ_W;
   localparam int PROD_W   = ssms_pkg::PROD_W;
   localparam int DEN_W    = ssms_pkg::DEN_W;
   localparam int QUO_W    = ssms_pkg::QUO_W;
   localparam int ERR_W    = ssms_pkg::ERR_W;
   localparam int STEP_W   = ssms_pkg::STEP_W;
   localparam int RT_REM_W = ERR_W + 2;

   // control
   ssms_pkg::state_type  state_ff, state_in;
   logic [STEP_W-1:0]    step_ff;
   logic                 counting;
   logic                 last_step;
   logic                 accept;
   logic                 load_rsp;

   // item registers
   ssms_pkg::req_kind_type op_ff;
   ssms_pkg::status_type   status_ff;
   logic                   apply_ff;
   logic [SAMPLE_W-1:0]    sample_ff;

   // store
   logic [SAMPLE_W-1:0]  store_mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0]  rd_data_ff;
   logic [COUNT_W-1:0]   top_idx;
   logic                 store_full;
   logic                 store_empty;

   // running state
   logic [COUNT_W-1:0]   count_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SQSUM_W-1:0]   sqsum_ff;

   // sample square
   logic [SAMPLE_W-1:0]  ld_sample;
   logic [SAMPLE_W-1:0]  ld_mag;
   logic [SAMPLE_W-1:0]  sq_mplr_ff;
   logic [SQ_W-1:0]      sq_mcand_ff;
   logic [SQ_W-1:0]      sq_acc_ff;
   logic [SUM_W-1:0]     sample_ext;

   // products and mean divider
   logic [SUM_W-1:0]     sum_mag;
   logic                 s1_neg_ff;
   logic [SUM_W-1:0]     s1sq_mplr_ff;
   logic [PROD_W-1:0]    s1sq_mcand_ff;
   logic [PROD_W-1:0]    s1sq_acc_ff;
   logic [COUNT_W-1:0]   ns2_mplr_ff;
   logic [PROD_W-1:0]    ns2_mcand_ff;
   logic [PROD_W-1:0]    ns2_acc_ff;
   logic [COUNT_W-1:0]   nn_mplr_ff;
   logic [DEN_W-1:0]     nn_mcand_ff;
   logic [DEN_W-1:0]     nn_ff;
   logic [COUNT_W-1:0]   nm1_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [SUM_W-1:0]     md_dvd_ff;
   logic [COUNT_W-1:0]   md_rem_ff;
   logic [SAMPLE_W-1:0]  md_quo_ff;
   logic [COUNT_W:0]     md_remx;
   logic [COUNT_W:0]     md_sub;
   logic                 md_ge;
   logic [SAMPLE_W-1:0]  mean_ff;

   // variance divider
   logic [PROD_W-1:0]    diff;
   logic [PROD_W-1:0]    dv_dvd_ff;
   logic [DEN_W-1:0]     dv_rem_ff;
   logic [QUO_W-1:0]     dv_quo_ff;
   logic                 dv_over_ff;
   logic [DEN_W:0]       dv_remx;
   logic [DEN_W:0]       dv_sub;
   logic                 dv_ge;

   // square root
   logic [RT_REM_W-1:0]  rt_rem_ff;
   logic [ERR_W-1:0]     rt_root_ff;
   logic [RT_REM_W+1:0]  rt_remx;
   logic [RT_REM_W+1:0]  rt_trial;
   logic [RT_REM_W+1:0]  rt_sub;
   logic                 rt_ge;
   logic [ERR_W-1:0]     std_err;

   // response register
   logic                        rsp_valid_ff;
   logic [ssms_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [ssms_pkg::RSP_TUSER_W-1:0] rsp_user_ff;

   assign top_idx     = count_ff - COUNT_W'(1);
   assign store_full  = (count_ff == COUNT_W'(STORE_DEPTH));
   assign store_empty = (count_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssms_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ssms_pkg::ST_LOAD;
         end
         ssms_pkg::ST_LOAD:   state_in = ssms_pkg::ST_SQUARE;
         ssms_pkg::ST_SQUARE: begin
            if (last_step) state_in = ssms_pkg::ST_APPLY;
         end
         ssms_pkg::ST_APPLY:  state_in = ssms_pkg::ST_PREP;
         ssms_pkg::ST_PREP:   state_in = ssms_pkg::ST_MULT;
         ssms_pkg::ST_MULT: begin
            if (last_step) state_in = ssms_pkg::ST_DIFF;
         end
         ssms_pkg::ST_DIFF:   state_in = ssms_pkg::ST_DIVIDE;
         ssms_pkg::ST_DIVIDE: begin
            if (last_step) state_in = ssms_pkg::ST_ROOT;
         end
         ssms_pkg::ST_ROOT: begin
            if (last_step) state_in = ssms_pkg::ST_FINISH;
         end
         ssms_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ssms_pkg::ST_IDLE;
         end
         default:             state_in = ssms_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      counting   = 1'b0;
      last_step  = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ssms_pkg::ST_IDLE:   req_tready = 1'b1;
         ssms_pkg::ST_SQUARE: begin
            counting  = 1'b1;
            last_step = (step_ff == STEP_W'(ssms_pkg::SQ_STEPS - 1));
         end
         ssms_pkg::ST_MULT: begin
            counting  = 1'b1;
            last_step = (step_ff == STEP_W'(ssms_pkg::MUL_STEPS - 1));
         end
         ssms_pkg::ST_DIVIDE: begin
            counting  = 1'b1;
            last_step = (step_ff == STEP_W'(ssms_pkg::DIV_STEPS - 1));
         end
         ssms_pkg::ST_ROOT: begin
            counting  = 1'b1;
            last_step = (step_ff == STEP_W'(ssms_pkg::ROOT_STEPS - 1));
         end
         ssms_pkg::ST_FINISH: load_rsp = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // control registers and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssms_pkg::ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= (counting && !last_step) ? step_ff + STEP_W'(1) : '0;
         if (state_ff == ssms_pkg::ST_APPLY && apply_ff) begin
            if (op_ff == ssms_pkg::REQ_PUSH) begin
               count_ff <= count_ff + COUNT_W'(1);
               sum_ff   <= sum_ff + sample_ext;
               sqsum_ff <= sqsum_ff + SQSUM_W'(sq_acc_ff);
            end else begin
               count_ff <= count_ff - COUNT_W'(1);
               sum_ff   <= sum_ff - sample_ext;
               sqsum_ff <= sqsum_ff - SQSUM_W'(sq_acc_ff);
            end
         end
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // sample store: write on an accepted push to a store that is not full, registered read of the top entry
   always_ff @(posedge clock) begin
      if (accept && req_tuser[0] == ssms_pkg::REQ_PUSH && !store_full) begin
         store_mem[count_ff[ADDR_W-1:0]] <= req_tdata;
      end
      rd_data_ff <= store_mem[top_idx[ADDR_W-1:0]];
   end

   // sample magnitude and sign extension
   assign ld_sample  = (op_ff == ssms_pkg::REQ_POP) ? rd_data_ff : sample_ff;
   assign ld_mag     = ld_sample[SAMPLE_W-1] ? (~ld_sample + SAMPLE_W'(1)) : ld_sample;
   assign sample_ext = {{(SUM_W - SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
   assign sum_mag    = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;

   // mean divider step
   assign md_remx = {md_rem_ff, md_dvd_ff[SUM_W-1]};
   assign md_sub  = md_remx - {1'b0, count_ff};
   assign md_ge   = (md_remx >= {1'b0, count_ff});

   // variance difference and divider step
   assign diff    = ns2_acc_ff - s1sq_acc_ff;
   assign dv_remx = {dv_rem_ff, dv_dvd_ff[PROD_W-1]};
   assign dv_sub  = dv_remx - {1'b0, den_ff};
   assign dv_ge   = (dv_remx >= {1'b0, den_ff});

   // square root step, two radicand bits at a time
   assign rt_remx  = {rt_rem_ff, dv_quo_ff[QUO_W-1 -: 2]};
   assign rt_trial = {2'b00, rt_root_ff, 2'b01};
   assign rt_sub   = rt_remx - rt_trial;
   assign rt_ge    = (rt_remx >= rt_trial);

   assign std_err = (count_ff < COUNT_W'(2)) ? '0
                  : (dv_over_ff ? ssms_pkg::ERR_MAX : rt_root_ff);

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ssms_pkg::ST_IDLE: begin
            if (accept) begin
               op_ff     <= ssms_pkg::req_kind_type'(req_tuser[0]);
               sample_ff <= req_tdata;
               if (req_tuser[0] == ssms_pkg::REQ_PUSH) begin
                  status_ff <= store_full ? ssms_pkg::STATUS_FULL : ssms_pkg::STATUS_DONE;
                  apply_ff  <= !store_full;
               end else begin
                  status_ff <= store_empty ? ssms_pkg::STATUS_EMPTY : ssms_pkg::STATUS_DONE;
                  apply_ff  <= !store_empty;
               end
            end
         end
         ssms_pkg::ST_LOAD: begin
            sample_ff   <= ld_sample;
            sq_mplr_ff  <= ld_mag;
            sq_mcand_ff <= SQ_W'(ld_mag);
            sq_acc_ff   <= '0;
         end
         // shift-add square, one multiplier bit a cycle
         ssms_pkg::ST_SQUARE: begin
            if (sq_mplr_ff[0]) sq_acc_ff <= sq_acc_ff + sq_mcand_ff;
            sq_mplr_ff  <= sq_mplr_ff >> 1;
            sq_mcand_ff <= sq_mcand_ff << 1;
         end
         ssms_pkg::ST_PREP: begin
            s1_neg_ff     <= sum_ff[SUM_W-1];
            s1sq_mplr_ff  <= sum_mag;
            s1sq_mcand_ff <= PROD_W'(sum_mag);
            s1sq_acc_ff   <= '0;
            ns2_mplr_ff   <= count_ff;
            ns2_mcand_ff  <= PROD_W'(sqsum_ff);
            ns2_acc_ff    <= '0;
            nn_mplr_ff    <= count_ff;
            nn_mcand_ff   <= DEN_W'(count_ff);
            nn_ff         <= '0;
            nm1_ff        <= top_idx;
            den_ff        <= '0;
            md_dvd_ff     <= sum_mag;
            md_rem_ff     <= '0;
            md_quo_ff     <= '0;
         end
         // S1^2, n*S2, n*n*(n-1) and S1/n side by side
         ssms_pkg::ST_MULT: begin
            if (s1sq_mplr_ff[0]) s1sq_acc_ff <= s1sq_acc_ff + s1sq_mcand_ff;
            s1sq_mplr_ff  <= s1sq_mplr_ff >> 1;
            s1sq_mcand_ff <= s1sq_mcand_ff << 1;
            if (ns2_mplr_ff[0]) ns2_acc_ff <= ns2_acc_ff + ns2_mcand_ff;
            ns2_mplr_ff  <= ns2_mplr_ff >> 1;
            ns2_mcand_ff <= ns2_mcand_ff << 1;
            // n*n first, then the square is shifted through by the bits of n-1
            if (step_ff < STEP_W'(COUNT_W)) begin
               if (nn_mplr_ff[0]) nn_ff <= nn_ff + nn_mcand_ff;
               nn_mplr_ff  <= nn_mplr_ff >> 1;
               nn_mcand_ff <= nn_mcand_ff << 1;
            end else begin
               if (nm1_ff[0]) den_ff <= den_ff + nn_ff;
               nn_ff  <= nn_ff << 1;
               nm1_ff <= nm1_ff >> 1;
            end
            md_rem_ff <= md_ge ? md_sub[COUNT_W-1:0] : md_remx[COUNT_W-1:0];
            md_quo_ff <= {md_quo_ff[SAMPLE_W-2:0], md_ge};
            md_dvd_ff <= md_dvd_ff << 1;
         end
         ssms_pkg::ST_DIFF: begin
            dv_dvd_ff  <= diff[PROD_W-1] ? '0 : diff;
            dv_rem_ff  <= '0;
            dv_quo_ff  <= '0;
            dv_over_ff <= 1'b0;
            if (store_empty) mean_ff <= '0;
            else mean_ff <= s1_neg_ff ? (~md_quo_ff + SAMPLE_W'(1)) : md_quo_ff;
         end
         // restoring division, quotient bits above the kept range saturate
         ssms_pkg::ST_DIVIDE: begin
            dv_rem_ff <= dv_ge ? dv_sub[DEN_W-1:0] : dv_remx[DEN_W-1:0];
            dv_quo_ff <= {dv_quo_ff[QUO_W-2:0], dv_ge};
            dv_dvd_ff <= dv_dvd_ff << 1;
            if (dv_ge && step_ff < STEP_W'(ssms_pkg::OVER_STEPS)) dv_over_ff <= 1'b1;
            rt_rem_ff  <= '0;
            rt_root_ff <= '0;
         end
         ssms_pkg::ST_ROOT: begin
            rt_rem_ff  <= rt_ge ? rt_sub[RT_REM_W-1:0] : rt_remx[RT_REM_W-1:0];
            rt_root_ff <= {rt_root_ff[ERR_W-2:0], rt_ge};
            dv_quo_ff  <= dv_quo_ff << 2;
         end
         ssms_pkg::ST_FINISH: begin
            if (load_rsp) begin
               rsp_data_ff <= {{ssms_pkg::RSP_PAD_W{1'b0}}, std_err, mean_ff, count_ff};
               rsp_user_ff <= {status_ff, (count_ff >= COUNT_W'(2))};
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

[rtl/ssms_checker.sv]
// ssms_checker: port-level checks on the responses of sample_stack_mean_stderr,
// bound to the top level at the end of this file
// depends on ssms_pkg
`default_nettype none

module ssms_checker #(
   parameter int STORE_DEPTH = 1024
) (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [ssms_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire [ssms_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   localparam int COUNT_W = ssms_pkg::COUNT_W;
   localparam int MEAN_LO = COUNT_W;
   localparam int ERR_LO  = MEAN_LO + ssms_pkg::SAMPLE_W;

   logic [COUNT_W-1:0]              rsp_count;
   logic [ssms_pkg::SAMPLE_W-1:0]   rsp_mean;
   logic [ssms_pkg::ERR_W-1:0]      rsp_err;
   logic                            rsp_err_valid;
   logic [ssms_pkg::STATUS_W-1:0]   rsp_status;

   assign rsp_count     = rsp_tdata[COUNT_W-1:0];
   assign rsp_mean      = rsp_tdata[MEAN_LO +: ssms_pkg::SAMPLE_W];
   assign rsp_err       = rsp_tdata[ERR_LO +: ssms_pkg::ERR_W];
   assign rsp_err_valid = rsp_tuser[0];
   assign rsp_status    = rsp_tuser[ssms_pkg::STATUS_W:1];

   // error flag follows the count
   a_err_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_err_valid == (rsp_count >= COUNT_W'(2))))
      else $error("error_valid disagrees with sample_count");

   // an empty stack reports zero mean and zero error
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_count == '0 |-> rsp_mean == '0 && rsp_err == '0)
      else $error("empty stack with nonzero mean or error");

   // a dropped push only happens on a full stack, an ignored pop only on an empty one
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ssms_pkg::STATUS_FULL |-> rsp_count == COUNT_W'(STORE_DEPTH))
      else $error("push dropped while stack not full");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ssms_pkg::STATUS_EMPTY |-> rsp_count == '0)
      else $error("pop ignored while stack not empty");

   // a stalled response transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

endmodule

bind sample_stack_mean_stderr ssms_checker #(
   .STORE_DEPTH (STORE_DEPTH)
) u_ssms_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[test/stack_stats_monitor.sv]
`timescale 1ns / 100ps
// stack_stats_monitor: watches both streams of the sample stack statistics block, keeps its
// own copy of the stack and sums, and checks count, mean and standard error of every response
// depends on ssms_pkg
module stack_stats_monitor #(
   parameter int STORE_DEPTH = 1024
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   input  wire                                 req_tready,
   input  wire  [ssms_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [23:0] sample
   input  wire  [ssms_pkg::REQ_TUSER_W-1:0]    req_tuser,   // [0] req_type
   input  wire                                 rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire  [ssms_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [10:0] sample_count,
                                                            // [34:11] mean_value,
                                                            // [57:35] std_error, rest zero
   input  wire  [ssms_pkg::RSP_TUSER_W-1:0]    rsp_tuser,   // [0] error_valid, [2:1] status
   output int                                  mismatch_total,
   output int                                  awaited_count
);

   localparam int COUNT_W     = ssms_pkg::COUNT_W;
   localparam int SAMPLE_W    = ssms_pkg::SAMPLE_W;
   localparam int ERR_W       = ssms_pkg::ERR_W;
   localparam int QUO_W       = ssms_pkg::QUO_W;
   localparam int RSP_TDATA_W = ssms_pkg::RSP_TDATA_W;
   localparam int RSP_PAD_W   = ssms_pkg::RSP_PAD_W;

   typedef struct {
      logic [COUNT_W-1:0]   count;
      logic [SAMPLE_W-1:0]  mean;
      logic [ERR_W-1:0]     serr;
      logic                 err_valid;
      ssms_pkg::status_type status;
   } stats_type;

   // predicted stack contents and running sums
   logic [SAMPLE_W-1:0] stack_mem [STORE_DEPTH];
   int                  held;
   longint              sum_acc;
   longint unsigned     sq_acc;
   stats_type           awaited_stats [$];

   // floor of the square root, for radicands below the saturation point
   function automatic logic [ERR_W-1:0] floor_root(logic [QUO_W-1:0] radicand);
      logic [ERR_W-1:0] root;
      logic [ERR_W-1:0] trial;
      root = '0;
      for (int b = ERR_W - 1; b >= 0; b--) begin
         trial = root | (ERR_W'(1) << b);
         if (QUO_W'(trial) * QUO_W'(trial) <= radicand)
            root = trial;
      end
      return root;
   endfunction

   // apply one request to the predicted stack and work out the statistics that follow
   function automatic stats_type next_stats(ssms_pkg::req_kind_type kind,
                                            logic [SAMPLE_W-1:0] smp);
      stats_type       res;
      longint          value;
      longint          n;
      longint          mag;
      longint unsigned square;
      logic [127:0]    lhs;
      logic [127:0]    rhs;
      logic [127:0]    spread;
      logic [127:0]    quo;
      res.status = ssms_pkg::STATUS_DONE;
      if (kind == ssms_pkg::REQ_PUSH) begin
         if (held >= STORE_DEPTH) begin
            res.status = ssms_pkg::STATUS_FULL;
         end else begin
            value = $signed(smp);
            square = value * value;
            stack_mem[held] = smp;
            held++;
            sum_acc += value;
            sq_acc += square;
         end
      end else if (held == 0) begin
         res.status = ssms_pkg::STATUS_EMPTY;
      end else begin
         held--;
         value = $signed(stack_mem[held]);
         square = value * value;
         sum_acc -= value;
         sq_acc -= square;
      end

      n = held;
      res.count = COUNT_W'(held);
      res.mean = '0;
      res.serr = '0;
      res.err_valid = 1'b0;
      if (n > 0)
         res.mean = SAMPLE_W'(sum_acc / n);
      if (n >= 2) begin
         mag = (sum_acc < 0) ? -sum_acc : sum_acc;
         lhs = 128'(n) * 128'(sq_acc);
         rhs = 128'(mag) * 128'(mag);
         spread = (lhs >= rhs) ? lhs - rhs : '0;
         quo = spread / (128'(n) * 128'(n) * 128'(n - 1));
         // a root of 2^23 or more no longer fits the error field
         res.serr = (quo >= (128'(1) << QUO_W)) ? ssms_pkg::ERR_MAX
                                                : floor_root(quo[QUO_W-1:0]);
         res.err_valid = 1'b1;
      end
      return res;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatch_total++;
         if (mismatch_total <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // response check first, then the request accepted at the same edge
   always @(posedge clock) begin : watch
      stats_type want;
      if (reset) begin
         held = 0;
         sum_acc = 0;
         sq_acc = 0;
         mismatch_total = 0;
         awaited_stats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_stats.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: response transfer with none outstanding, tdata %0h tuser %0h",
                           $time, rsp_tdata, rsp_tuser);
            end else begin
               want = awaited_stats.pop_front();
               compare_field("sample_count", 64'(want.count), 64'(rsp_tdata[COUNT_W-1:0]));
               compare_field("mean_value", 64'(want.mean),
                             64'(rsp_tdata[COUNT_W +: SAMPLE_W]));
               compare_field("std_error", 64'(want.serr),
                             64'(rsp_tdata[COUNT_W+SAMPLE_W +: ERR_W]));
               compare_field("padding", 64'(0),
                             64'(rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W]));
               compare_field("error_valid", 64'(want.err_valid), 64'(rsp_tuser[0]));
               compare_field("status", 64'(want.status), 64'(rsp_tuser[2:1]));
            end
         end
         if (req_tvalid && req_tready)
            awaited_stats.insert(awaited_stats.size(),
                                 next_stats(ssms_pkg::req_kind_type'(req_tuser[0]),
                                            req_tdata[SAMPLE_W-1:0]));
      end
      awaited_count <= awaited_stats.size();
   end

endmodule

[test/sample_stack_mean_stderr_tb.sv]
`timescale 1ns / 100ps
// sample_stack_mean_stderr_tb: drives pushes and pops into the sample stack statistics block
// under varying stalls and gives the verdict; depends on ssms_pkg, sample_stack_mean_stderr
// and stack_stats_monitor
module sample_stack_mean_stderr_tb;

   localparam int STORE_DEPTH    = 1024;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int SAMPLE_W       = ssms_pkg::SAMPLE_W;
   localparam int REQ_TDATA_W    = ssms_pkg::REQ_TDATA_W;
   localparam int REQ_TUSER_W    = ssms_pkg::REQ_TUSER_W;
   localparam int RSP_TDATA_W    = ssms_pkg::RSP_TDATA_W;
   localparam int RSP_TUSER_W    = ssms_pkg::RSP_TUSER_W;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic [REQ_TUSER_W-1:0]  req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [RSP_TUSER_W-1:0]  rsp_tuser;

   int                      mismatch_total;
   int                      awaited_count;
   int                      stall_cycles   = 0;
   int                      send_idle_pct  = 17;
   int                      recv_idle_pct  = 54;
   logic [SAMPLE_W-1:0]     cluster_centre = '0;

   sample_stack_mean_stderr #(
      .STORE_DEPTH (STORE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   stack_stats_monitor #(
      .STORE_DEPTH (STORE_DEPTH)
   ) monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_total (mismatch_total),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("sample_stack_mean_stderr_tb: errors");
            $finish;
         end
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic issue_item(ssms_pkg::req_kind_type kind, logic [SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= kind;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
   endtask

   // hold off until every outstanding response has gone out
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0)
         @(posedge clock);
   endtask

   // mix of extremes, small values, tight clusters and full-range values
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         1, 2:    return SAMPLE_W'($urandom_range(8191)) - 24'd4096;
         3:       return cluster_centre + SAMPLE_W'($urandom_range(63));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // bursts that grow, shrink or hover around the current depth
   task automatic random_ops(int total);
      int issued;
      int burst;
      int pop_pct;
      issued = 0;
      while (issued < total) begin
         burst = $urandom_range(24, 1);
         case ($urandom_range(3))
            0:       pop_pct = 10;
            1:       pop_pct = 80;
            2:       pop_pct = 50;
            default: pop_pct = 30;
         endcase
         cluster_centre = SAMPLE_W'($urandom);
         repeat (burst) begin
            issue_item(($urandom_range(99) < pop_pct) ? ssms_pkg::REQ_POP : ssms_pkg::REQ_PUSH,
                       pick_sample());
            issued++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 17;
      recv_idle_pct = 54;
      issue_item(ssms_pkg::REQ_POP, 24'h000000);        // pop on empty
      issue_item(ssms_pkg::REQ_PUSH, 24'h7FFFFF);       // single sample, largest value
      issue_item(ssms_pkg::REQ_PUSH, 24'h800000);       // widest spread, largest error
      issue_item(ssms_pkg::REQ_POP, 24'hFFFFFF);
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      issue_item(ssms_pkg::REQ_POP, 24'h7FFFFF);        // empty again
      issue_item(ssms_pkg::REQ_PUSH, 24'h800000);       // single sample, smallest value
      issue_item(ssms_pkg::REQ_PUSH, 24'h800000);       // no spread
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      issue_item(ssms_pkg::REQ_PUSH, 24'h000001);
      issue_item(ssms_pkg::REQ_PUSH, 24'h000002);       // positive mean truncated
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      issue_item(ssms_pkg::REQ_PUSH, 24'hFFFFFF);
      issue_item(ssms_pkg::REQ_PUSH, 24'hFFFFFE);       // negative mean truncated toward zero
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      issue_item(ssms_pkg::REQ_PUSH, 24'h7FFFFF);
      issue_item(ssms_pkg::REQ_PUSH, 24'h7FFFFF);       // largest mean
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      issue_item(ssms_pkg::REQ_POP, 24'h000000);
      random_ops(170);
      wait_for_responses();

      // the other way round
      send_idle_pct = 54;
      recv_idle_pct = 17;
      random_ops(170);
      wait_for_responses();

      // no idling: a long run of pushes, then mixed work at depth
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (120) issue_item(ssms_pkg::REQ_PUSH, pick_sample());
      random_ops(110);
      wait_for_responses();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && awaited_count == 0)
         $display("sample_stack_mean_stderr_tb: clean");
      else
         $display("sample_stack_mean_stderr_tb: errors");
      $finish;
   end

endmodule
